// ----- sv/cdq_pkg.sv -----
// ----------------------------------------------------------------------------
// cdq_pkg
// shared constants and types for the circular deque
// ----------------------------------------------------------------------------
`default_nettype none

package cdq_pkg;

  localparam int unsigned DEPTH   = 16;
  localparam int unsigned IDX_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W   = $clog2(DEPTH + 1);
  localparam int unsigned DATA_W  = 32;
  localparam int unsigned FILL_W  = 5;

  typedef enum logic [1:0] {
    REQ_PUSH_REAR  = 2'd0,
    REQ_PUSH_FRONT = 2'd1,
    REQ_POP_FRONT  = 2'd2,
    REQ_POP_REAR   = 2'd3
  } req_type_e;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  // memory access issued by the pointer logic
  typedef struct packed {
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
  } cdq_mem_op_t;

  // outcome of one request, known at the transfer
  typedef struct packed {
    status_e           status;
    logic              pop_done;
    logic [FILL_W-1:0] fill;
  } cdq_result_t;

endpackage

`default_nettype wire

// ----- sv/cdq_ram.sv -----
// ----------------------------------------------------------------------------
// cdq_ram
// ring storage, one write and one registered read per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module cdq_ram (
  input  wire logic                  clk_i,
  input  wire cdq_pkg::cdq_mem_op_t  op_i,
  input  wire logic [cdq_pkg::DATA_W-1:0] wr_data_i,
  output logic [cdq_pkg::DATA_W-1:0] rd_data_o
);
  import cdq_pkg::*;

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (op_i.wr_en) begin
      mem[op_i.wr_addr] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (op_i.rd_en) begin
      rd_data_o <= mem[op_i.rd_addr];
    end
  end

endmodule

`default_nettype wire

// ----- sv/cdq_ctrl.sv -----
// ----------------------------------------------------------------------------
// cdq_ctrl
// head, tail and count registers; decides each request and its slot
// ----------------------------------------------------------------------------
`default_nettype none

module cdq_ctrl (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 accept_i,
  input  wire cdq_pkg::req_type_e   req_i,
  output cdq_pkg::cdq_mem_op_t      op_o,
  output cdq_pkg::cdq_result_t      res_o
);
  import cdq_pkg::*;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  logic [IDX_W-1:0] head_q, head_d;
  logic [IDX_W-1:0] tail_q, tail_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;

  logic [IDX_W-1:0] head_up, head_dn, tail_up, tail_dn;
  logic             is_full, is_empty;

  assign head_up  = (head_q == LAST_IDX) ? '0 : head_q + 1'b1;
  assign head_dn  = (head_q == '0) ? LAST_IDX : head_q - 1'b1;
  assign tail_up  = (tail_q == LAST_IDX) ? '0 : tail_q + 1'b1;
  assign tail_dn  = (tail_q == '0) ? LAST_IDX : tail_q - 1'b1;
  assign is_full  = (cnt_q == FULL_CNT);
  assign is_empty = (cnt_q == '0);

  always_comb begin
    head_d        = head_q;
    tail_d        = tail_q;
    cnt_d         = cnt_q;
    op_o          = '0;
    res_o.status  = ST_DONE;
    res_o.pop_done = 1'b0;
    case (req_i)
      REQ_PUSH_REAR: begin
        if (is_full) begin
          res_o.status = ST_FULL;
        end else begin
          op_o.wr_en   = accept_i;
          op_o.wr_addr = tail_q;
          tail_d       = tail_up;
          cnt_d        = cnt_q + 1'b1;
        end
      end
      REQ_PUSH_FRONT: begin
        if (is_full) begin
          res_o.status = ST_FULL;
        end else begin
          op_o.wr_en   = accept_i;
          op_o.wr_addr = head_dn;
          head_d       = head_dn;
          cnt_d        = cnt_q + 1'b1;
        end
      end
      REQ_POP_FRONT: begin
        if (is_empty) begin
          res_o.status = ST_EMPTY;
        end else begin
          op_o.rd_en     = accept_i;
          op_o.rd_addr   = head_q;
          res_o.pop_done = 1'b1;
          head_d         = head_up;
          cnt_d          = cnt_q - 1'b1;
        end
      end
      REQ_POP_REAR: begin
        if (is_empty) begin
          res_o.status = ST_EMPTY;
        end else begin
          op_o.rd_en     = accept_i;
          op_o.rd_addr   = tail_dn;
          res_o.pop_done = 1'b1;
          tail_d         = tail_dn;
          cnt_d          = cnt_q - 1'b1;
        end
      end
      default: begin
        res_o.status = ST_DONE;
      end
    endcase
    res_o.fill = FILL_W'(cnt_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= '0;
      tail_q <= '0;
      cnt_q  <= '0;
    end else if (accept_i) begin
      head_q <= head_d;
      tail_q <= tail_d;
      cnt_q  <= cnt_d;
    end
  end

endmodule

`default_nettype wire

// ----- sv/circular_deque.sv -----
// ----------------------------------------------------------------------------
// circular_deque
// double-ended queue of 32-bit words in a ring held in one synchronous ram
// ----------------------------------------------------------------------------
// result path: after its request transfer a result passes the ram read stage,
//   then the output register
// throughput: one request per cycle while the result side keeps up;
//   pointers and count update at the transfer, the ram port does the rest
// reset: head, tail and count clear, ring reads as empty; ram not cleared
`default_nettype none

module circular_deque (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic [1:0]                    req_type_i,
  input  wire logic signed [cdq_pkg::DATA_W-1:0] data_value_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic [1:0]                         status_o,
  output logic signed [cdq_pkg::DATA_W-1:0]  popped_value_o,
  output logic [cdq_pkg::FILL_W-1:0]         fill_level_o
);
  import cdq_pkg::*;

  logic              accept;
  logic              s1_valid_q;
  cdq_result_t       s1_res_q;
  cdq_mem_op_t       mem_op;
  cdq_result_t       res;
  logic [DATA_W-1:0] rd_data;
  logic              out_load;

  logic              out_valid_q;
  logic [1:0]        status_q;
  logic [DATA_W-1:0] popped_q;
  logic [FILL_W-1:0] fill_q;

  assign out_load   = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || out_load;
  assign accept     = in_valid_i && in_ready_o;

  cdq_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .req_i    (req_type_e'(req_type_i)),
    .op_o     (mem_op),
    .res_o    (res)
  );

  cdq_ram u_ram (
    .clk_i     (clk_i),
    .op_i      (mem_op),
    .wr_data_i (data_value_i),
    .rd_data_o (rd_data)
  );

  // read stage: rd_data holds until the next transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_res_q <= res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      status_q <= s1_res_q.status;
      popped_q <= s1_res_q.pop_done ? rd_data : '0;
      fill_q   <= s1_res_q.fill;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = status_q;
  assign popped_value_o = popped_q;
  assign fill_level_o   = fill_q;

  // refusals leave the count at its bound
  a_full_level: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o == ST_FULL) |-> (fill_level_o == FILL_W'(DEPTH)))
    else $error("full refusal with fill level below depth");

  a_empty_level: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o == ST_EMPTY) |-> (fill_level_o == '0))
    else $error("empty refusal with nonzero fill level");

  a_refused_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o != ST_DONE) |-> (popped_value_o == '0))
    else $error("refused request returned a word");

  // a transfer while the read stage is full must drain it the same cycle
  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && s1_valid_q) |-> out_load)
    else $error("read stage overwritten");

endmodule

`default_nettype wire
